### rtl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants for the sequential list engine.
// ----------------------------------------------------------------------------
package lst_pkg;

   localparam int DEPTH      = 256;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 9;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // find tree: groups of GROUP cells, one priority encoder each
   localparam int GROUP  = (DEPTH >= 16) ? 16 : DEPTH;
   localparam int GRP_W  = $clog2(GROUP);
   localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      OP_INSERT     = 3'd0,
      OP_ERASE      = 3'd1,
      OP_FIND       = 3'd2,
      OP_PUSH_BACK  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_PUSH_FRONT = 3'd5,
      OP_POP_FRONT  = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic             shift_up;
      logic             shift_down;
      logic             find;
      logic [CMP_W-1:0] pos;
      logic [CNT_W-1:0] count;
      word_type         value;
   } cell_cmd_type;

endpackage

### rtl/lst_cell.sv
// ----------------------------------------------------------------------------
// lst_cell
// One list slot: holds a word, takes a neighbor's word on shifts, and
// registers a match flag for find.
// ----------------------------------------------------------------------------
module lst_cell (
   input  logic                     clock,
   input  logic [lst_pkg::IDX_W-1:0] cell_idx,
   input  lst_pkg::cell_cmd_type     cmd,
   input  lst_pkg::word_type         left_word,
   input  lst_pkg::word_type         right_word,
   output lst_pkg::word_type         word,
   output logic                      match
);
   import lst_pkg::*;

   word_type         word_ff, word_in;
   logic             match_ff, match_in;
   logic [CMP_W-1:0] idx_ext;

   always_comb begin
      idx_ext = CMP_W'(cell_idx);
      word_in = word_ff;
      if (cmd.shift_up) begin
         if (idx_ext > cmd.pos) begin
            word_in = left_word;
         end else if (idx_ext == cmd.pos) begin
            word_in = cmd.value;
         end
      end else if (cmd.shift_down && (idx_ext >= cmd.pos)) begin
         word_in = right_word;
      end
      match_in = cmd.find ? ((CNT_W'(cell_idx) < cmd.count) && (word_ff == cmd.value))
                          : match_ff;
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      match_ff <= match_in;
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

### rtl/lst_find.sv
// ----------------------------------------------------------------------------
// lst_find
// Two-level lowest-index search over the cell match flags; the group
// results are registered.
// ----------------------------------------------------------------------------
module lst_find (
   input  logic                      clock,
   input  logic [lst_pkg::DEPTH-1:0] match,
   output logic                      hit,
   output logic [lst_pkg::IDX_W-1:0] index
);
   import lst_pkg::*;

   logic             grp_hit_ff [NGROUP];
   logic             grp_hit_in [NGROUP];
   logic [GRP_W-1:0] grp_idx_ff [NGROUP];
   logic [GRP_W-1:0] grp_idx_in [NGROUP];

   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_hit_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int k = GROUP - 1; k >= 0; k--) begin
            if ((g * GROUP + k) < DEPTH) begin
               if (match[g * GROUP + k]) begin
                  grp_hit_in[g] = 1'b1;
                  grp_idx_in[g] = GRP_W'(k);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_hit_ff[g] <= grp_hit_in[g];
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int g = NGROUP - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            hit   = 1'b1;
            index = IDX_W'(g * GROUP) + IDX_W'(grp_idx_ff[g]);
         end
      end
   end

endmodule

### rtl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed words held in a row of shifting cells, with
// insert, erase, push, pop, find and clear, one response per request.
//
//   channel | direction | words
//   req_    | in        | operation, position, value
//   rsp_    | out       | status, found, found_index, count
//
// Insert, erase, push and pop shift the whole row at once; clear resets count.
// Find: cell compare, group encode, final encode.
// One request is in flight at a time; req_stall is high during a find and
// while a response waits with rsp_stall high.
// Reset empties the list; stored words are not cleared.
// ----------------------------------------------------------------------------
module sequential_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [8:0]  req_position,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [7:0]  rsp_found_index,
   output logic [8:0]  rsp_count
);
   import lst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_MATCH = 3'b010,
      S_GROUP = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [7:0]       rsp_found_index_ff, rsp_found_index_in;
   logic [8:0]       rsp_count_ff, rsp_count_in;

   logic             out_free;
   logic             req_accept;
   op_type           op;
   word_type         req_word;
   logic [CMP_W-1:0] pos_ext, cnt_ext, tgt_pos;
   logic             ins_req, era_req;
   status_type       op_status;
   cell_cmd_type     cmd;
   word_type         words [DEPTH];
   logic [DEPTH-1:0] match_vec;
   logic             find_hit;
   logic [IDX_W-1:0] find_index;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign op         = op_type'(req_operation);
   assign req_word   = DATA_WIDTH'($unsigned(req_value));
   assign pos_ext    = CMP_W'(req_position);
   assign cnt_ext    = CMP_W'(count_ff);

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_found_in       = rsp_found_ff;
      rsp_found_index_in = rsp_found_index_ff;
      rsp_count_in       = rsp_count_ff;
      ins_req            = 1'b0;
      era_req            = 1'b0;
      tgt_pos            = pos_ext;
      op_status          = ST_OK;
      cmd.shift_up       = 1'b0;
      cmd.shift_down     = 1'b0;
      cmd.find           = 1'b0;
      cmd.count          = count_ff;
      cmd.value          = req_word;

      unique case (op)
         OP_INSERT:     ins_req = 1'b1;
         OP_ERASE:      era_req = 1'b1;
         OP_PUSH_BACK:  begin ins_req = 1'b1; tgt_pos = cnt_ext; end
         OP_POP_BACK:   begin era_req = 1'b1; tgt_pos = cnt_ext - CMP_W'(1); end
         OP_PUSH_FRONT: begin ins_req = 1'b1; tgt_pos = '0; end
         OP_POP_FRONT:  begin era_req = 1'b1; tgt_pos = '0; end
         default:       ;
      endcase
      cmd.pos = tgt_pos;

      if (ins_req) begin
         if (tgt_pos > cnt_ext) begin
            op_status = ST_BAD;
         end else if (cnt_ext == CMP_W'(DEPTH)) begin
            op_status = ST_FULL;
         end
      end else if (era_req) begin
         if ((count_ff == '0) || (tgt_pos >= cnt_ext)) begin
            op_status = ST_BAD;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (op == OP_FIND) begin
                  cmd.find = 1'b1;
                  state_in = S_MATCH;
               end else begin
                  if (op == OP_CLEAR) begin
                     count_in = '0;
                  end else if (op_status == ST_OK) begin
                     if (ins_req) begin
                        cmd.shift_up = 1'b1;
                        count_in     = count_ff + CNT_W'(1);
                     end else begin
                        cmd.shift_down = 1'b1;
                        count_in       = count_ff - CNT_W'(1);
                     end
                  end
                  rsp_valid_in       = 1'b1;
                  rsp_status_in      = op_status;
                  rsp_found_in       = 1'b0;
                  rsp_found_index_in = '0;
                  rsp_count_in       = 9'(count_in);
               end
            end
         end
         S_MATCH: begin
            state_in = S_GROUP;
         end
         S_GROUP: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = ST_OK;
               rsp_found_in       = find_hit;
               rsp_found_index_in = find_hit ? 8'(find_index) : 8'd0;
               rsp_count_in       = 9'(count_ff);
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff      <= rsp_status_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_found_index_ff <= rsp_found_index_in;
      rsp_count_ff       <= rsp_count_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_word, right_word;
      if (i == 0) begin : g_first
         assign left_word = words[i];
      end else begin : g_left
         assign left_word = words[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = words[i];
      end else begin : g_right
         assign right_word = words[i+1];
      end
      lst_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .cmd        (cmd),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[i]),
         .match      (match_vec[i])
      );
   end

   lst_find u_find (
      .clock (clock),
      .match (match_vec),
      .hit   (find_hit),
      .index (find_index)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_count       = rsp_count_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count beyond capacity");

   a_find_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken during find");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (op == OP_CLEAR)) |=> (count_ff == '0) && (rsp_count == 9'd0))
      else $error("clear left entries");

   a_found_in_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (9'(rsp_found_index) < rsp_count))
      else $error("found index outside list");

endmodule

### dv/sequential_list_engine_tb.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_tb
// Self-checking bench for the sequential list engine. A directed table covers
// the empty list, range errors and the full list. Random grow, shrink and
// mixed phases follow. Every response word is checked against the table or a
// shadow copy, with random idling on both channels and two long hold-offs.
// ----------------------------------------------------------------------------
module sequential_list_engine_tb;
   import lst_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_WORDS = 950;
   localparam int LONG_HOLD    = 400;

   typedef struct packed {
      status_type status;
      logic       found;
      logic [7:0] found_index;
      logic [8:0] count;
   } rsp_word_type;

   typedef struct {
      op_type       op;
      logic [8:0]   pos;
      logic [31:0]  val;
      bit           known;
      rsp_word_type want;
   } req_row_type;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} list_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation = '0;
   logic [8:0]  req_position = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [7:0]  rsp_found_index;
   logic [8:0]  rsp_count;

   word_type      shadow_mem [DEPTH];
   int            shadow_len = 0;
   rsp_word_type  rsp_expected [$];
   req_row_type   dir_rows [$];
   int            mismatches = 0;
   int            cycles = 0;
   int            sent_words = 0;
   bit            send_burst = 0;
   list_mode_type list_mode = MODE_GROW;

   sequential_list_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 16);
   endfunction

   // shadow list operations
   function automatic status_type shadow_put(int p, word_type w);
      if (p > shadow_len) return ST_BAD;
      if (shadow_len >= DEPTH) return ST_FULL;
      for (int i = shadow_len; i > p; i--) shadow_mem[i] = shadow_mem[i-1];
      shadow_mem[p] = w;
      shadow_len++;
      return ST_OK;
   endfunction

   function automatic status_type shadow_cut(int p);
      if (p >= shadow_len) return ST_BAD;
      for (int i = p; i < shadow_len - 1; i++) shadow_mem[i] = shadow_mem[i+1];
      shadow_len--;
      return ST_OK;
   endfunction

   function automatic rsp_word_type list_predict(op_type op, logic [8:0] pos, word_type w);
      rsp_word_type r;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_INSERT:     r.status = shadow_put(int'(pos), w);
         OP_ERASE:      r.status = shadow_cut(int'(pos));
         OP_FIND: begin
            for (int i = 0; i < shadow_len; i++) begin
               if (shadow_mem[i] == w) begin
                  r.found = 1'b1;
                  r.found_index = i[7:0];
                  break;
               end
            end
         end
         OP_PUSH_BACK:  r.status = shadow_put(shadow_len, w);
         OP_POP_BACK:   r.status = (shadow_len == 0) ? ST_BAD : shadow_cut(shadow_len - 1);
         OP_PUSH_FRONT: r.status = shadow_put(0, w);
         OP_POP_FRONT:  r.status = shadow_cut(0);
         default:       shadow_len = 0;
      endcase
      r.count = shadow_len[8:0];
      return r;
   endfunction

   task automatic send_word(input op_type op, input logic [8:0] pos, input logic [31:0] val,
                            input bit known, input rsp_word_type want);
      int           gap;
      rsp_word_type pred;
      gap = draw_wait(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_value     <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = list_predict(op, pos, val);
      rsp_expected.push_back(known ? want : pred);
      sent_words++;
      if (sent_words % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
   endtask

   task automatic add_row(op_type op, int pos, logic [31:0] val);
      req_row_type row;
      row.op = op;
      row.pos = pos[8:0];
      row.val = val;
      row.known = 1'b0;
      row.want = '0;
      dir_rows.push_back(row);
   endtask

   task automatic add_known(op_type op, int pos, logic [31:0] val, status_type st, bit f,
                            int idx, int cnt);
      req_row_type row;
      row.op = op;
      row.pos = pos[8:0];
      row.val = val;
      row.known = 1'b1;
      row.want.status = st;
      row.want.found = f;
      row.want.found_index = idx[7:0];
      row.want.count = cnt[8:0];
      dir_rows.push_back(row);
   endtask

   task automatic pick_item(output op_type op, output logic [8:0] pos, output logic [31:0] val);
      int r;
      int len;
      len = shadow_len;
      r = $urandom_range(0, 99);
      case (list_mode)
         MODE_GROW:
            op = r < 30 ? OP_PUSH_BACK : r < 55 ? OP_PUSH_FRONT : r < 88 ? OP_INSERT :
                 r < 95 ? OP_FIND : r < 97 ? OP_ERASE : r < 98 ? OP_POP_BACK : OP_POP_FRONT;
         MODE_SHRINK:
            op = r < 30 ? OP_ERASE : r < 52 ? OP_POP_BACK : r < 74 ? OP_POP_FRONT :
                 r < 84 ? OP_FIND : r < 90 ? OP_INSERT : r < 94 ? OP_PUSH_BACK :
                 r < 98 ? OP_PUSH_FRONT : OP_CLEAR;
         default:
            op = r < 15 ? OP_INSERT : r < 30 ? OP_ERASE : r < 50 ? OP_FIND :
                 r < 62 ? OP_PUSH_BACK : r < 74 ? OP_POP_BACK : r < 86 ? OP_PUSH_FRONT :
                 r < 98 ? OP_POP_FRONT : OP_CLEAR;
      endcase
      if ($urandom_range(0, 99) < 85) pos = 9'($urandom_range(0, len));
      else pos = 9'($urandom_range(0, 511));
      r = $urandom_range(0, 99);
      if (r < 40 && len > 0) val = shadow_mem[$urandom_range(0, len - 1)];
      else if (r < 60) begin
         case ($urandom_range(0, 4))
            0: val = 32'h0000_0000;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'h7FFF_FFFF;
            3: val = 32'h8000_0000;
            default: val = $urandom_range(0, 7);
         endcase
      end else val = $urandom();
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response word, expected none, got status %0h count %0h",
                     $time, rsp_status, rsp_count);
         end else begin
            e = rsp_expected.pop_front();
            check_field("status", 32'(e.status), 32'(rsp_status));
            check_field("found", 32'(e.found), 32'(rsp_found));
            check_field("found_index", 32'(e.found_index), 32'(rsp_found_index));
            check_field("count", 32'(e.count), 32'(rsp_count));
         end
      end
   end

   // response side idling
   initial begin
      int  hold;
      int  taken;
      bit  burst;
      taken = 0;
      burst = 0;
      wait (!reset);
      forever begin
         if (taken == 300 || taken == 900) hold = LONG_HOLD;
         else hold = draw_wait(burst);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if (taken % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      op_type      op;
      logic [8:0]  pos;
      logic [31:0] val;
      int          fill_at;

      // empty list and range errors
      add_known(OP_POP_BACK,   0,     32'h0,         ST_BAD, 0, 0, 0);
      add_known(OP_POP_FRONT,  9'h1FF, 32'hFFFF_FFFF, ST_BAD, 0, 0, 0);
      add_known(OP_ERASE,      0,     32'h0,         ST_BAD, 0, 0, 0);
      add_known(OP_FIND,       0,     32'h0,         ST_OK,  0, 0, 0);
      add_known(OP_INSERT,     1,     32'h5,         ST_BAD, 0, 0, 0);
      add_known(OP_INSERT,     0,     32'h7FFF_FFFF, ST_OK,  0, 0, 1);
      add_known(OP_PUSH_BACK,  0,     32'h8000_0000, ST_OK,  0, 0, 2);
      add_known(OP_PUSH_FRONT, 9'h1FF, 32'hFFFF_FFFF, ST_OK,  0, 0, 3);
      add_known(OP_FIND,       0,     32'hFFFF_FFFF, ST_OK,  1, 0, 3);
      add_known(OP_FIND,       511,   32'h8000_0000, ST_OK,  1, 2, 3);
      add_known(OP_INSERT,     3,     32'h0,         ST_OK,  0, 0, 4);
      add_known(OP_INSERT,     511,   32'h1,         ST_BAD, 0, 0, 4);
      add_known(OP_ERASE,      4,     32'h0,         ST_BAD, 0, 0, 4);
      add_row(OP_INSERT,    1, 32'h5555_AAAA);
      add_row(OP_PUSH_BACK, 0, 32'h5555_AAAA);
      add_row(OP_FIND,      0, 32'h5555_AAAA);
      add_row(OP_ERASE,     0, 32'h0);
      add_row(OP_POP_BACK,  0, 32'h0);
      add_row(OP_POP_FRONT, 0, 32'h0);
      add_row(OP_FIND,      0, 32'h0001_2345);
      add_known(OP_CLEAR,      9'h1FF, 32'hFFFF_FFFF, ST_OK,  0, 0, 0);
      add_known(OP_FIND,       0,     32'h7FFF_FFFF, ST_OK,  0, 0, 0);
      add_known(OP_POP_FRONT,  0,     32'h0,         ST_BAD, 0, 0, 0);
      fill_at = dir_rows.size();
      // full list
      add_known(OP_PUSH_BACK,  0,     32'h1,         ST_FULL, 0, 0, 256);
      add_known(OP_PUSH_FRONT, 0,     32'h1,         ST_FULL, 0, 0, 256);
      add_known(OP_INSERT,     256,   32'h1,         ST_FULL, 0, 0, 256);
      add_known(OP_INSERT,     257,   32'h1,         ST_BAD,  0, 0, 256);
      add_known(OP_ERASE,      255,   32'h0,         ST_OK,   0, 0, 255);
      add_known(OP_INSERT,     255,   32'hC0DE_F00D, ST_OK,   0, 0, 256);
      add_row(OP_FIND, 0, 32'hC0DE_F00D);
      add_known(OP_CLEAR,      0,     32'h0,         ST_OK,   0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < dir_rows.size(); i++) begin
         if (i == fill_at) begin
            for (int j = 0; j < DEPTH; j++) send_word(OP_PUSH_BACK, 9'd0, $urandom(), 1'b0, '0);
         end
         send_word(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].known,
                   dir_rows[i].want);
      end

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         list_mode = (k < 320) ? MODE_GROW : (k < 640) ? MODE_SHRINK : MODE_MIX;
         pick_item(op, pos, val);
         send_word(op, pos, val, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/lst_pkg.sv
rtl/lst_cell.sv
rtl/lst_find.sv
rtl/sequential_list_engine.sv
dv/sequential_list_engine_tb.sv
